FILE: hdl/fraction_add_mul_reduce_macros.svh
// assertion macros for the fraction_add_mul_reduce checker
// depends on nothing; the user supplies clock and reset in scope
`ifndef FRACTION_ADD_MUL_REDUCE_MACROS_SVH
`define FRACTION_ADD_MUL_REDUCE_MACROS_SVH

// checked on every rising clock edge, skipped while reset is high
`define FAM_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked on every rising clock edge, reset included
`define FAM_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

FILE: hdl/fam_pkg.sv
// shared types and constants for the fraction add / multiply / reduce block
// no dependencies
`timescale 1ns / 1ps

package fam_pkg;

   localparam int FUNC_W    = 2;
   localparam int RES_NUM_W = 33;
   localparam int RES_DEN_W = 32;

   // operation codes; the fourth code is unused and gives an all-zero word
   typedef enum logic [FUNC_W-1:0] {
      OP_ADD = 2'd0,
      OP_MUL = 2'd1,
      OP_EQ  = 2'd2
   } func_type;

   // status from the shared subtract unit
   typedef struct packed {
      logic borrow;
      logic zero;
   } sub_stat_type;

endpackage

FILE: hdl/fam_mul.sv
// registered multiplier shared by all product steps
// depends on nothing outside this file
`timescale 1ns / 1ps

module fam_mul #(
   parameter int OPW = 16
) (
   input  logic             clock,
   input  logic [OPW-1:0]   op_a,
   input  logic [OPW-1:0]   op_b,
   output logic [2*OPW-1:0] prod
);

   logic [2*OPW-1:0] prod_ff;
   logic [2*OPW-1:0] prod_in;

   assign prod_in = (2*OPW)'(op_a) * (2*OPW)'(op_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

FILE: hdl/fam_subu.sv
// shared subtract / compare unit used by the gcd steps and the divider
// depends on fam_pkg for the status struct
`timescale 1ns / 1ps

module fam_subu #(
   parameter int SW = 34
) (
   input  logic [SW-1:0]         sub_a,
   input  logic [SW-1:0]         sub_b,
   output logic [SW-1:0]         diff,
   output logic [SW-1:0]         mag,
   output fam_pkg::sub_stat_type stat
);

   logic [SW:0] full;

   assign full        = {1'b0, sub_a} - {1'b0, sub_b};
   assign diff        = full[SW-1:0];
   assign stat.borrow = full[SW];
   assign stat.zero   = (full[SW-1:0] == '0);
   // magnitude of the difference, negated back when the smaller value is on the left
   assign mag         = full[SW] ? (~full[SW-1:0] + {{(SW-1){1'b0}}, 1'b1}) : full[SW-1:0];

endmodule

FILE: hdl/fraction_add_mul_reduce.sv
// compare and unused codes give the result in the cycle after start
// add / multiply: products on the shared multiplier in states MUL0 to MUL3, then, if
//   numerator and denominator are both nonzero, binary gcd steps and 2*W divide steps,
//   W = 2*NUM_WIDTH+1 capped at 64
// one word at a time: for add / multiply, busy stays high from accept until the result strobe
// reset (synchronous) returns to idle and drops the strobe; the receiver cannot stall
`timescale 1ns / 1ps

module fraction_add_mul_reduce #(
   parameter int NUM_WIDTH = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [fam_pkg::FUNC_W-1:0]     req_func,
   input  logic [NUM_WIDTH-1:0]           req_a_num,
   input  logic [NUM_WIDTH-1:0]           req_a_den,
   input  logic [NUM_WIDTH-1:0]           req_b_num,
   input  logic [NUM_WIDTH-1:0]           req_b_den,
   output logic                           rsp_valid,
   output logic [fam_pkg::RES_NUM_W-1:0]  rsp_res_num,
   output logic [fam_pkg::RES_DEN_W-1:0]  rsp_res_den,
   output logic                           rsp_is_equal
);

   localparam int PW      = 2 * NUM_WIDTH;
   localparam int NW      = (PW + 1 > 64) ? 64 : PW + 1;
   localparam int SW      = NW + 1;
   localparam int CW      = $clog2(NW);
   localparam int ResNumW = fam_pkg::RES_NUM_W;
   localparam int ResDenW = fam_pkg::RES_DEN_W;

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_MUL0 = 7'b0000010,
      ST_MUL1 = 7'b0000100,
      ST_MUL2 = 7'b0001000,
      ST_MUL3 = 7'b0010000,
      ST_GCD  = 7'b0100000,
      ST_DIV  = 7'b1000000
   } state_type;

   state_type                     state_ff, state_in;
   logic [fam_pkg::FUNC_W-1:0]    func_ff, func_in;
   logic [NUM_WIDTH-1:0]          an_ff, an_in, ad_ff, ad_in;
   logic [NUM_WIDTH-1:0]          bn_ff, bn_in, bd_ff, bd_in;
   logic [NW-1:0]                 n_ff, n_in;
   logic [PW-1:0]                 d_ff, d_in;
   logic [NW-1:0]                 x_ff, x_in, y_ff, y_in;
   logic [CW-1:0]                 k_ff, k_in;
   logic [NW-1:0]                 g_ff, g_in;
   logic [NW-1:0]                 q_ff, q_in, rem_ff, rem_in;
   logic [CW-1:0]                 cnt_ff, cnt_in;
   logic                          pass_ff, pass_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [ResNumW-1:0]            rsp_num_ff, rsp_num_in;
   logic [ResDenW-1:0]            rsp_den_ff, rsp_den_in;
   logic                          rsp_eq_ff, rsp_eq_in;

   logic [NUM_WIDTH-1:0]          mul_a, mul_b;
   logic [PW-1:0]                 prod;
   logic [PW:0]                   sum_w;
   logic [SW-1:0]                 sub_a, sub_b, sub_diff, sub_mag;
   fam_pkg::sub_stat_type         sub_stat;
   logic [NW-1:0]                 q_next;
   logic                          is_arith;

   fam_mul #(.OPW(NUM_WIDTH)) u_mul (
      .clock (clock),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .prod  (prod)
   );

   fam_subu #(.SW(SW)) u_sub (
      .sub_a (sub_a),
      .sub_b (sub_b),
      .diff  (sub_diff),
      .mag   (sub_mag),
      .stat  (sub_stat)
   );

   // multiplier operands: first cross term (numerators for multiply), second cross term, denominators
   always_comb begin
      if (state_ff == ST_MUL0) begin
         mul_a = an_ff;
         mul_b = (func_ff == fam_pkg::OP_ADD) ? bd_ff : bn_ff;
      end else if (state_ff == ST_MUL1) begin
         mul_a = bn_ff;
         mul_b = ad_ff;
      end else begin
         mul_a = ad_ff;
         mul_b = bd_ff;
      end
   end

   // subtract unit: restoring divide trial, else gcd compare
   always_comb begin
      if (state_ff == ST_DIV) begin
         sub_a = {rem_ff, q_ff[NW-1]};
         sub_b = {1'b0, g_ff};
      end else begin
         sub_a = {1'b0, x_ff};
         sub_b = {1'b0, y_ff};
      end
   end

   assign sum_w    = {1'b0, n_ff[PW-1:0]} + {1'b0, prod};
   assign q_next   = {q_ff[NW-2:0], ~sub_stat.borrow};
   assign is_arith = (req_func == fam_pkg::OP_ADD) || (req_func == fam_pkg::OP_MUL);

   always_comb begin
      state_in     = state_ff;
      func_in      = func_ff;
      an_in        = an_ff;
      ad_in        = ad_ff;
      bn_in        = bn_ff;
      bd_in        = bd_ff;
      n_in         = n_ff;
      d_in         = d_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      k_in         = k_ff;
      g_in         = g_ff;
      q_in         = q_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      pass_in      = pass_ff;
      rsp_valid_in = 1'b0;
      rsp_num_in   = rsp_num_ff;
      rsp_den_in   = rsp_den_ff;
      rsp_eq_in    = rsp_eq_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               func_in = req_func;
               an_in   = req_a_num;
               ad_in   = req_a_den;
               bn_in   = req_b_num;
               bd_in   = req_b_den;
               if (is_arith) begin
                  state_in = ST_MUL0;
               end else begin
                  rsp_valid_in = 1'b1;
                  rsp_num_in   = '0;
                  rsp_den_in   = '0;
                  rsp_eq_in    = (req_func == fam_pkg::OP_EQ) &&
                                 (req_a_num == req_b_num) && (req_a_den == req_b_den);
               end
            end
         end
         ST_MUL0: begin
            state_in = ST_MUL1;
         end
         ST_MUL1: begin
            n_in     = NW'(prod);
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            if (func_ff == fam_pkg::OP_ADD) begin
               n_in = NW'(sum_w);
            end
            state_in = ST_MUL3;
         end
         ST_MUL3: begin
            d_in = prod;
            // zero numerator or denominator stays unreduced
            if ((n_ff == '0) || (prod == '0)) begin
               rsp_valid_in = 1'b1;
               rsp_num_in   = ResNumW'(n_ff);
               rsp_den_in   = ResDenW'(prod);
               rsp_eq_in    = 1'b0;
               state_in     = ST_IDLE;
            end else begin
               x_in     = n_ff;
               y_in     = NW'(prod);
               k_in     = '0;
               state_in = ST_GCD;
            end
         end
         ST_GCD: begin
            if (!x_ff[0] && !y_ff[0]) begin
               x_in = x_ff >> 1;
               y_in = y_ff >> 1;
               k_in = k_ff + 1'b1;
            end else if (!x_ff[0]) begin
               x_in = x_ff >> 1;
            end else if (!y_ff[0]) begin
               y_in = y_ff >> 1;
            end else if (sub_stat.zero) begin
               g_in     = x_ff << k_ff;
               q_in     = n_ff;
               rem_in   = '0;
               cnt_in   = '0;
               pass_in  = 1'b0;
               state_in = ST_DIV;
            end else if (!sub_stat.borrow) begin
               x_in = sub_mag[NW:1];
            end else begin
               y_in = sub_mag[NW:1];
            end
         end
         ST_DIV: begin
            rem_in = sub_stat.borrow ? sub_a[NW-1:0] : sub_diff[NW-1:0];
            q_in   = q_next;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CW'(NW - 1)) begin
               if (!pass_ff) begin
                  // numerator done, start on the denominator
                  n_in    = q_next;
                  q_in    = NW'(d_ff);
                  rem_in  = '0;
                  cnt_in  = '0;
                  pass_in = 1'b1;
               end else begin
                  rsp_valid_in = 1'b1;
                  rsp_num_in   = ResNumW'(n_ff);
                  rsp_den_in   = ResDenW'(q_next);
                  rsp_eq_in    = 1'b0;
                  state_in     = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         pass_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         pass_ff      <= pass_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff    <= func_in;
      an_ff      <= an_in;
      ad_ff      <= ad_in;
      bn_ff      <= bn_in;
      bd_ff      <= bd_in;
      n_ff       <= n_in;
      d_ff       <= d_in;
      x_ff       <= x_in;
      y_ff       <= y_in;
      k_ff       <= k_in;
      g_ff       <= g_in;
      q_ff       <= q_in;
      rem_ff     <= rem_in;
      cnt_ff     <= cnt_in;
      rsp_num_ff <= rsp_num_in;
      rsp_den_ff <= rsp_den_in;
      rsp_eq_ff  <= rsp_eq_in;
   end

   assign busy         = (state_ff != ST_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_res_num  = rsp_num_ff;
   assign rsp_res_den  = rsp_den_ff;
   assign rsp_is_equal = rsp_eq_ff;

endmodule

FILE: hdl/fam_checker.sv
// port-level checks for fraction_add_mul_reduce, attached by bind
// depends on fam_pkg and fraction_add_mul_reduce_macros.svh
`timescale 1ns / 1ps
`include "fraction_add_mul_reduce_macros.svh"

module fam_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          start,
   input logic                          busy,
   input logic [fam_pkg::FUNC_W-1:0]    req_func,
   input logic                          rsp_valid,
   input logic [fam_pkg::RES_NUM_W-1:0] rsp_res_num,
   input logic [fam_pkg::RES_DEN_W-1:0] rsp_res_den,
   input logic                          rsp_is_equal
);

   logic accept;
   logic arith_req;
   logic rsp_zero;

   assign accept    = start && !busy;
   assign arith_req = (req_func == fam_pkg::OP_ADD) || (req_func == fam_pkg::OP_MUL);
   assign rsp_zero  = (rsp_res_num == '0) && (rsp_res_den == '0);

   // an arithmetic word keeps the block busy
   `FAM_ASSERT(a_arith_busy, accept && arith_req |=> busy, "arithmetic word did not raise busy")

   // compare and unused codes answer in the next cycle
   `FAM_ASSERT(a_cmp_quick, accept && !arith_req |=> rsp_valid && !busy, "compare word late")

   // the end of busy always comes with a result
   `FAM_ASSERT(a_done_strobe, $fell(busy) && !$past(reset) |-> rsp_valid, "busy fell alone")

   // no result while a word is still at work
   `FAM_ASSERT_ALWAYS(a_no_rsp_busy, rsp_valid |-> !busy, "result strobe while busy")

   // an equal flag comes only with a zero fraction
   `FAM_ASSERT(a_eq_zero, rsp_valid && rsp_is_equal |-> rsp_zero, "equal flag on nonzero result")

endmodule

bind fraction_add_mul_reduce fam_checker u_fam_checker (
   .clock        (clock),
   .reset        (reset),
   .start        (start),
   .busy         (busy),
   .req_func     (req_func),
   .rsp_valid    (rsp_valid),
   .rsp_res_num  (rsp_res_num),
   .rsp_res_den  (rsp_res_den),
   .rsp_is_equal (rsp_is_equal)
);

FILE: sim/tb.sv
// self-checking bench for fraction_add_mul_reduce: directed table, then random words
// depends on fam_pkg and the fraction_add_mul_reduce top level
`timescale 1ns / 1ps

module tb;

   localparam int OPER_W = 16;
   localparam int DRAIN_CYCLES = 150;
   localparam int STALL_LIMIT = 2000;
   localparam int RANDOM_WORDS = 950;
   localparam int DIRECTED_WORDS = 24;
   localparam logic [fam_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;

   typedef struct packed {
      logic [fam_pkg::FUNC_W-1:0] func;
      logic [OPER_W-1:0]          a_num;
      logic [OPER_W-1:0]          a_den;
      logic [OPER_W-1:0]          b_num;
      logic [OPER_W-1:0]          b_den;
   } fraction_req_type;

   typedef struct packed {
      logic [fam_pkg::RES_NUM_W-1:0] num;
      logic [fam_pkg::RES_DEN_W-1:0] den;
      logic                          eq;
   } fraction_result_type;

   typedef struct packed {
      fraction_req_type    req;
      logic                known;
      fraction_result_type res;
   } directed_row_type;

   // known rows carry the answer; the rest go through the predictor
   localparam directed_row_type DIRECTED_ROWS [DIRECTED_WORDS] = '{
      '{'{fam_pkg::OP_EQ, 16'd5, 16'd7, 16'd5, 16'd7}, 1'b1, '{33'd0, 32'd0, 1'b1}},
      '{'{fam_pkg::OP_EQ, 16'd5, 16'd7, 16'd5, 16'd8}, 1'b1, '{33'd0, 32'd0, 1'b0}},
      '{'{fam_pkg::OP_EQ, 16'd65535, 16'd65535, 16'd65535, 16'd65535}, 1'b1,
        '{33'd0, 32'd0, 1'b1}},
      '{'{fam_pkg::OP_EQ, 16'd0, 16'd1, 16'd0, 16'd2}, 1'b1, '{33'd0, 32'd0, 1'b0}},
      '{'{fam_pkg::OP_EQ, 16'd3, 16'd9, 16'd1, 16'd3}, 1'b1, '{33'd0, 32'd0, 1'b0}},
      '{'{FUNC_UNUSED, 16'd65535, 16'd65535, 16'd65535, 16'd65535}, 1'b1,
        '{33'd0, 32'd0, 1'b0}},
      '{'{FUNC_UNUSED, 16'd0, 16'd1, 16'd0, 16'd1}, 1'b1, '{33'd0, 32'd0, 1'b0}},
      '{'{fam_pkg::OP_ADD, 16'd0, 16'd7, 16'd0, 16'd9}, 1'b1, '{33'd0, 32'd63, 1'b0}},
      '{'{fam_pkg::OP_MUL, 16'd0, 16'd65535, 16'd65535, 16'd65535}, 1'b1,
        '{33'd0, 32'd4294836225, 1'b0}},
      '{'{fam_pkg::OP_MUL, 16'd65535, 16'd65535, 16'd65535, 16'd65535}, 1'b1,
        '{33'd1, 32'd1, 1'b0}},
      '{'{fam_pkg::OP_ADD, 16'd65535, 16'd65535, 16'd65535, 16'd65535}, 1'b1,
        '{33'd2, 32'd1, 1'b0}},
      '{'{fam_pkg::OP_ADD, 16'd65535, 16'd1, 16'd65535, 16'd1}, 1'b1,
        '{33'd131070, 32'd1, 1'b0}},
      '{'{fam_pkg::OP_MUL, 16'd65535, 16'd1, 16'd65535, 16'd1}, 1'b1,
        '{33'd4294836225, 32'd1, 1'b0}},
      '{'{fam_pkg::OP_MUL, 16'd1, 16'd65535, 16'd1, 16'd65535}, 1'b1,
        '{33'd1, 32'd4294836225, 1'b0}},
      '{'{fam_pkg::OP_ADD, 16'd1, 16'd3, 16'd1, 16'd6}, 1'b1, '{33'd1, 32'd2, 1'b0}},
      // zero denominators pass through unreduced
      '{'{fam_pkg::OP_ADD, 16'd1, 16'd0, 16'd1, 16'd1}, 1'b1, '{33'd1, 32'd0, 1'b0}},
      '{'{fam_pkg::OP_MUL, 16'd3, 16'd0, 16'd5, 16'd7}, 1'b1, '{33'd15, 32'd0, 1'b0}},
      '{'{fam_pkg::OP_ADD, 16'd0, 16'd0, 16'd0, 16'd5}, 1'b1, '{33'd0, 32'd0, 1'b0}},
      '{'{fam_pkg::OP_ADD, 16'd1, 16'd65535, 16'd1, 16'd65534}, 1'b0, '0},
      '{'{fam_pkg::OP_ADD, 16'd65535, 16'd65534, 16'd65535, 16'd65533}, 1'b0, '0},
      '{'{fam_pkg::OP_MUL, 16'd12, 16'd35, 16'd14, 16'd9}, 1'b0, '0},
      '{'{fam_pkg::OP_ADD, 16'd32768, 16'd43690, 16'd21845, 16'd32768}, 1'b0, '0},
      '{'{fam_pkg::OP_MUL, 16'd43690, 16'd21845, 16'd21845, 16'd43690}, 1'b0, '0},
      '{'{fam_pkg::OP_ADD, 16'd65534, 16'd3, 16'd1, 16'd65535}, 1'b0, '0}
   };

   logic                          clock = 1'b0;
   logic                          reset;
   logic                          start;
   logic                          busy;
   logic [fam_pkg::FUNC_W-1:0]    req_func;
   logic [OPER_W-1:0]             req_a_num;
   logic [OPER_W-1:0]             req_a_den;
   logic [OPER_W-1:0]             req_b_num;
   logic [OPER_W-1:0]             req_b_den;
   logic                          rsp_valid;
   logic [fam_pkg::RES_NUM_W-1:0] rsp_res_num;
   logic [fam_pkg::RES_DEN_W-1:0] rsp_res_den;
   logic                          rsp_is_equal;

   fraction_result_type pending_results[$];
   int mismatch_count = 0;
   int results_checked = 0;
   int stall_cycles = 0;
   int words_sent = 0;
   int adds_sent = 0;
   int muls_sent = 0;
   int compares_sent = 0;
   int unused_sent = 0;
   int burst_left = 0;

   fraction_add_mul_reduce #(.NUM_WIDTH(OPER_W)) dut (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_func     (req_func),
      .req_a_num    (req_a_num),
      .req_a_den    (req_a_den),
      .req_b_num    (req_b_num),
      .req_b_den    (req_b_den),
      .rsp_valid    (rsp_valid),
      .rsp_res_num  (rsp_res_num),
      .rsp_res_den  (rsp_res_den),
      .rsp_is_equal (rsp_is_equal)
   );

   always #6 clock = ~clock;

   // exact sum or product, divided through by the gcd
   function automatic fraction_result_type exact_fraction(input fraction_req_type w);
      longint unsigned top;
      longint unsigned bottom;
      longint unsigned x;
      longint unsigned y;
      longint unsigned t;
      fraction_result_type r;
      top = 0;
      bottom = 0;
      r = '0;
      case (w.func)
         fam_pkg::OP_ADD: begin
            top = 64'(w.a_num) * 64'(w.b_den) + 64'(w.b_num) * 64'(w.a_den);
            bottom = 64'(w.a_den) * 64'(w.b_den);
         end
         fam_pkg::OP_MUL: begin
            top = 64'(w.a_num) * 64'(w.b_num);
            bottom = 64'(w.a_den) * 64'(w.b_den);
         end
         fam_pkg::OP_EQ: begin
            r.eq = (w.a_num == w.b_num) && (w.a_den == w.b_den);
         end
         default: ;
      endcase
      if (top != 0 && bottom != 0) begin
         x = top;
         y = bottom;
         while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
         end
         top = top / x;
         bottom = bottom / x;
      end
      r.num = top[fam_pkg::RES_NUM_W-1:0];
      r.den = bottom[fam_pkg::RES_DEN_W-1:0];
      return r;
   endfunction

   function automatic logic [OPER_W-1:0] pick_operand(input bit nonzero);
      logic [OPER_W-1:0] v;
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 9: v = OPER_W'($urandom);
         4, 5: v = OPER_W'($urandom_range(0, 20));
         6: v = OPER_W'(16'hffff - $urandom_range(0, 3));
         7: v = OPER_W'(1) << $urandom_range(0, OPER_W - 1);
         default: v = OPER_W'($urandom_range(0, 255));
      endcase
      if (nonzero && v == 0)
         v = 1;
      return v;
   endfunction

   function automatic fraction_req_type random_word();
      fraction_req_type w;
      int unsigned roll;
      int unsigned factor;
      roll = $urandom_range(0, 99);
      w.a_num = pick_operand(1'b0);
      w.a_den = pick_operand(1'b1);
      w.b_num = pick_operand(1'b0);
      w.b_den = pick_operand(1'b1);
      if (roll < 40)
         w.func = fam_pkg::OP_ADD;
      else if (roll < 80)
         w.func = fam_pkg::OP_MUL;
      else if (roll < 96)
         w.func = fam_pkg::OP_EQ;
      else
         w.func = FUNC_UNUSED;
      if (w.func == fam_pkg::OP_EQ) begin
         // equal pairs half the time, sometimes with one field off by one
         if ($urandom_range(0, 1) == 1) begin
            w.b_num = w.a_num;
            w.b_den = w.a_den;
            if ($urandom_range(0, 3) == 0)
               w.b_den = w.b_den ^ OPER_W'(1);
         end
      end else if ($urandom_range(0, 3) == 0) begin
         // shared factor so the reduction has real work to do
         factor = $urandom_range(2, 255);
         w.a_num = OPER_W'($urandom_range(0, 255) * factor);
         w.a_den = OPER_W'($urandom_range(1, 255) * factor);
         w.b_num = OPER_W'($urandom_range(0, 255) * factor);
         w.b_den = OPER_W'($urandom_range(1, 255) * factor);
      end
      return w;
   endfunction

   function automatic int gap_length();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 50)
         return 0;
      else if (roll < 85)
         return $urandom_range(1, 3);
      else if (roll < 97)
         return $urandom_range(4, 20);
      else
         return $urandom_range(30, 80);
   endfunction

   task automatic send_word(input fraction_req_type w, input fraction_result_type want);
      start     <= 1'b1;
      req_func  <= w.func;
      req_a_num <= w.a_num;
      req_a_den <= w.a_den;
      req_b_num <= w.b_num;
      req_b_den <= w.b_den;
      @(posedge clock);
      while (busy)
         @(posedge clock);
      pending_results.push_back(want);
      words_sent++;
      case (w.func)
         fam_pkg::OP_ADD: adds_sent++;
         fam_pkg::OP_MUL: muls_sent++;
         fam_pkg::OP_EQ: compares_sent++;
         default: unused_sent++;
      endcase
   endtask

   task automatic idle_for(input int cycles);
      if (cycles > 0) begin
         start <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   task automatic wait_for_results();
      start <= 1'b0;
      do
         @(posedge clock);
      while (pending_results.size() != 0);
   endtask

   // zero gap for a run of words every so often, random gaps otherwise
   task automatic sender_gap(input int index);
      if (index % 100 == 50)
         burst_left = 40;
      if (burst_left > 0)
         burst_left--;
      else
         idle_for(gap_length());
   endtask

   initial begin
      fraction_req_type w;
      reset     = 1'b1;
      start     = 1'b0;
      req_func  = '0;
      req_a_num = '0;
      req_a_den = '0;
      req_b_num = '0;
      req_b_den = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIRECTED_WORDS; i++) begin
         w = DIRECTED_ROWS[i].req;
         send_word(w, DIRECTED_ROWS[i].known ? DIRECTED_ROWS[i].res : exact_fraction(w));
         idle_for(gap_length());
      end

      for (int i = 0; i < RANDOM_WORDS; i++) begin
         w = random_word();
         send_word(w, exact_fraction(w));
         // hold off now and then until the block has answered everything
         if (i % 200 == 199)
            wait_for_results();
         sender_gap(i);
      end

      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("tb: %0d words (%0d add, %0d multiply, %0d compare, %0d unused code)",
               words_sent, adds_sent, muls_sent, compares_sent, unused_sent);
      $display("tb: %0d results checked, %0d mismatches", results_checked, mismatch_count);
      if (mismatch_count == 0 && pending_results.size() == 0)
         $display("tb: clean");
      else
         $display("tb: errors");
      $finish;
   end

   always @(posedge clock) begin
      fraction_result_type want;
      if (!reset && rsp_valid) begin
         if (pending_results.size() == 0) begin
            $error("result word with nothing outstanding: num %0d den %0d eq %0d",
                   rsp_res_num, rsp_res_den, rsp_is_equal);
            mismatch_count++;
         end else begin
            want = pending_results.pop_front();
            results_checked++;
            if (rsp_res_num !== want.num) begin
               $error("res_num: expected %0d, got %0d", want.num, rsp_res_num);
               mismatch_count++;
            end
            if (rsp_res_den !== want.den) begin
               $error("res_den: expected %0d, got %0d", want.den, rsp_res_den);
               mismatch_count++;
            end
            if (rsp_is_equal !== want.eq) begin
               $error("is_equal: expected %0d, got %0d", want.eq, rsp_is_equal);
               mismatch_count++;
            end
         end
      end
   end

   // cycles with neither an accepted request nor a result
   always @(posedge clock) begin
      if (reset || rsp_valid || (start && !busy)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("tb: no progress for %0d cycles, %0d results outstanding",
                  STALL_LIMIT, pending_results.size());
         $display("tb: errors");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

endmodule
